// ----- sv/assert_macros.svh -----
// Assertion macros used by the tokenizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/clt_pkg.sv -----
// Types, constants and helpers for the command line tokenizer.
package clt_pkg;

	localparam int LINE_MAX          = 64;
	localparam int MAX_PARAMS        = 10;
	localparam int PARAM_NAME_CHARS  = 10;
	localparam int PARAM_VALUE_CHARS = 20;

	localparam int FLD_MAX  = (PARAM_NAME_CHARS > PARAM_VALUE_CHARS) ?
		PARAM_NAME_CHARS : PARAM_VALUE_CHARS;
	localparam int BYTES_W  = $clog2(LINE_MAX + 1);
	localparam int NAME_W   = $clog2(LINE_MAX + 1);
	localparam int FLD_W    = $clog2(FLD_MAX);
	localparam int CNT_W    = 4;
	localparam int POS_W    = 6;
	localparam int CH_W     = 8;

	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
	localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
	localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;

	localparam logic [BYTES_W-1:0] BYTES_LIMIT = BYTES_W'(LINE_MAX - 2);
	localparam logic [FLD_W-1:0]   NAME_LAST   = FLD_W'(PARAM_NAME_CHARS - 1);
	localparam logic [FLD_W-1:0]   VALUE_LAST  = FLD_W'(PARAM_VALUE_CHARS - 1);
	localparam logic [CNT_W-1:0]   PARAMS_LAST = CNT_W'(MAX_PARAMS);

	typedef enum logic [1:0] {
		TGT_NONE,
		TGT_CMD,
		TGT_PNAME,
		TGT_PVALUE
	} target_t;

	typedef enum logic [1:0] {
		FP_IDLE,
		FP_NAME,
		FP_VALUE
	} fphase_t;

	typedef struct packed {
		logic               in_param_phase;
		logic               finished;
		logic               error_seen;
		logic [BYTES_W-1:0] bytes_seen;
		logic [NAME_W-1:0]  name_length;
		fphase_t            field_phase;
		logic               quoted;
		logic [FLD_W-1:0]   field_length;
		logic [CNT_W-1:0]   params_found;
	} tok_state_t;

	typedef struct packed {
		target_t            target;
		logic [CNT_W-1:0]   param_index;
		logic [POS_W-1:0]   position;
		logic [CH_W-1:0]    data;
		logic               done_res;
		logic               status;
		logic [CNT_W-1:0]   param_count;
	} tok_result_t;

	function automatic logic is_name_char(input logic [CH_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A) || (c == CH_USCORE);
	endfunction

endpackage

// ----- sv/command_line_tokenizer_core.sv -----
// Top level of the command line tokenizer: input register, step logic, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, ch                     | into block
//  out     | out_valid, out_ready, target, param_index, | out of block
//          | position, data, done_res, status,          |
//          | param_count                                |
//
// One item a cycle while the result is not stalled; the result is registered.
// The line state updates as an item moves from the input register to the
// result register, so each byte sees the state left by the one before.
// arst_n clears the line state and both valid flags.
// A stalled result holds; the input register fills behind it, then in_ready drops.
`include "assert_macros.svh"

module command_line_tokenizer_core import clt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CH_W-1:0]   ch,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        target,
	output logic [CNT_W-1:0]  param_index,
	output logic [POS_W-1:0]  position,
	output logic [CH_W-1:0]   data,
	output logic              done_res,
	output logic              status,
	output logic [CNT_W-1:0]  param_count
);

	logic            vld_s1;
	logic [CH_W-1:0] ch_s1;
	logic            out_valid_q;
	tok_result_t     res_q;
	tok_state_t      state_q;
	tok_state_t      state_nxt;
	tok_result_t     res_nxt;
	logic            adv;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !vld_s1 || adv;

	clt_step u_step (
		.cur (state_q),
		.ch  (ch_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= vld_s1;
				if (vld_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
		if (adv && vld_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign target      = res_q.target;
	assign param_index = res_q.param_index;
	assign position    = res_q.position;
	assign data        = res_q.data;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;
	assign param_count = res_q.param_count;

	`ASSERT_NEXT(a_line_end_clears, clk, arst_n, vld_s1 && adv && ch_s1 == CH_NUL, state_q == '0, "state not cleared after end of line")
	`ASSERT_IMPL(a_field_bound, clk, arst_n, 1'b1, state_q.field_length <= VALUE_LAST, "field length beyond limit")
	`ASSERT_IMPL(a_param_bound, clk, arst_n, 1'b1, state_q.params_found <= PARAMS_LAST, "parameter count beyond limit")
	`ASSERT_IMPL(a_idle_result, clk, arst_n, out_valid_q && res_q.target == TGT_NONE, res_q.position == '0 && res_q.data == '0 && res_q.param_index == '0, "no-write result carries payload")

endmodule

// ----- sv/clt_step.sv -----
// Next-state and result logic for one byte of the command line.
module clt_step import clt_pkg::*; (
	input  tok_state_t        cur,
	input  logic [CH_W-1:0]   ch,
	output tok_state_t        nxt,
	output tok_result_t       res
);

	logic             err;
	logic [CNT_W-1:0] pf;
	fphase_t          fp;

	always_comb begin
		nxt             = cur;
		res             = '0;
		res.target      = TGT_NONE;
		err             = cur.error_seen;
		pf              = cur.params_found;
		fp              = cur.field_phase;

		if (ch == CH_NUL) begin
			// close the line
			if (!cur.error_seen) begin
				if (!cur.in_param_phase) begin
					res.target   = TGT_CMD;
					res.position = cur.name_length[POS_W-1:0];
				end else begin
					if (fp == FP_VALUE && cur.field_length != '0) begin
						res.target   = TGT_PVALUE;
						res.position = POS_W'(cur.field_length);
						fp           = FP_IDLE;
					end else if (fp == FP_NAME) begin
						res.target   = TGT_PNAME;
						res.position = POS_W'(cur.field_length);
					end
					if (fp != FP_IDLE || cur.quoted) begin
						err = 1'b1;
					end
				end
			end
			res.done_res    = 1'b1;
			res.status      = err;
			res.param_count = cur.params_found;
			nxt             = '0;
			nxt.field_phase = FP_IDLE;
		end else if (cur.bytes_seen < BYTES_LIMIT) begin
			nxt.bytes_seen = cur.bytes_seen + 1'b1;
			if (!cur.finished && !cur.error_seen) begin
				if (!cur.in_param_phase) begin
					if (ch == CH_SPACE) begin
						if (cur.name_length != '0) begin
							res.target         = TGT_CMD;
							res.position       = cur.name_length[POS_W-1:0];
							nxt.in_param_phase = 1'b1;
						end
					end else if (is_name_char(ch)) begin
						res.target      = TGT_CMD;
						res.position    = cur.name_length[POS_W-1:0];
						res.data        = ch;
						nxt.name_length = cur.name_length + 1'b1;
					end else if (ch == CH_QMARK && cur.name_length == '0) begin
						res.target      = TGT_CMD;
						res.data        = ch;
						nxt.name_length = NAME_W'(1);
						nxt.finished    = 1'b1;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end else if (ch == CH_SPACE) begin
					if (cur.field_phase == FP_VALUE && !cur.quoted) begin
						if (cur.field_length != '0) begin
							res.target       = TGT_PVALUE;
							res.position     = POS_W'(cur.field_length);
							nxt.field_length = '0;
							nxt.field_phase  = FP_IDLE;
						end
					end else if (cur.quoted) begin
						if (cur.field_phase == FP_VALUE) begin
							if (cur.field_length >= VALUE_LAST) begin
								nxt.error_seen = 1'b1;
							end else begin
								res.target       = TGT_PVALUE;
								res.position     = POS_W'(cur.field_length);
								res.data         = ch;
								nxt.field_length = cur.field_length + 1'b1;
							end
						end else if (cur.field_phase == FP_NAME) begin
							nxt.error_seen = 1'b1;
						end
					end
				end else if (ch == CH_EQ) begin
					if (cur.field_phase == FP_NAME) begin
						res.target       = TGT_PNAME;
						res.position     = POS_W'(cur.field_length);
						nxt.field_length = '0;
						nxt.field_phase  = FP_VALUE;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end else if (ch == CH_QUOTE) begin
					nxt.quoted = !cur.quoted;
				end else if (cur.field_phase == FP_IDLE) begin
					// open a new parameter
					if (cur.params_found >= PARAMS_LAST) begin
						nxt.error_seen = 1'b1;
					end else if (!is_name_char(ch) || NAME_LAST == '0) begin
						pf               = cur.params_found + 1'b1;
						nxt.params_found = pf;
						nxt.field_phase  = FP_NAME;
						nxt.field_length = '0;
						nxt.error_seen   = 1'b1;
					end else begin
						pf               = cur.params_found + 1'b1;
						nxt.params_found = pf;
						nxt.field_phase  = FP_NAME;
						res.target       = TGT_PNAME;
						res.data         = ch;
						nxt.field_length = FLD_W'(1);
					end
				end else if (cur.field_phase == FP_NAME) begin
					if (!is_name_char(ch) || cur.field_length >= NAME_LAST) begin
						nxt.error_seen = 1'b1;
					end else begin
						res.target       = TGT_PNAME;
						res.position     = POS_W'(cur.field_length);
						res.data         = ch;
						nxt.field_length = cur.field_length + 1'b1;
					end
				end else begin
					if (cur.field_length >= VALUE_LAST) begin
						nxt.error_seen = 1'b1;
					end else begin
						res.target       = TGT_PVALUE;
						res.position     = POS_W'(cur.field_length);
						res.data         = ch;
						nxt.field_length = cur.field_length + 1'b1;
					end
				end
			end
		end

		if ((res.target == TGT_PNAME || res.target == TGT_PVALUE) && pf != '0) begin
			res.param_index = pf - 1'b1;
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the command line tokenizer: directed rows, then random lines.
`timescale 1ns / 1ps

module testbench import clt_pkg::*; ();

	localparam int ITEMS = 1900;
	localparam int LIMIT = 1000000;

	typedef struct {
		logic [CH_W-1:0] b;
		bit              fixed;
		tok_result_t     res;
	} row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CH_W-1:0]   ch = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        target;
	logic [CNT_W-1:0]  param_index;
	logic [POS_W-1:0]  position;
	logic [CH_W-1:0]   data;
	logic              done_res;
	logic              status;
	logic [CNT_W-1:0]  param_count;

	// tokenizer state as predicted from the accepted bytes
	logic              line_in_params;
	logic              line_done;
	logic              line_err;
	logic [6:0]        byte_cnt;
	logic [6:0]        cmd_len;
	fphase_t           fld_phase;
	logic              in_quote;
	logic [4:0]        fld_len;
	logic [3:0]        param_cnt;

	tok_result_t       pending_writes[$];
	tok_result_t       want;
	row_t              plan[$];
	logic [CH_W-1:0]   line_q[$];
	int                fails = 0;
	int                sent = 0;
	int                cycles = 0;
	int                hold_left = 0;
	bit                calm = 1'b0;

	command_line_tokenizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.target      (target),
		.param_index (param_index),
		.position    (position),
		.data        (data),
		.done_res    (done_res),
		.status      (status),
		.param_count (param_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic bit word_char(input logic [CH_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
			(c >= "A" && c <= "Z") || c == CH_USCORE;
	endfunction

	function automatic tok_result_t res_of(input target_t t, input int idx, input int pos,
		input logic [CH_W-1:0] d, input bit dn, input bit st, input int cnt);
		tok_result_t r;
		r.target = t;
		r.param_index = idx[CNT_W-1:0];
		r.position = pos[POS_W-1:0];
		r.data = d;
		r.done_res = dn;
		r.status = st;
		r.param_count = cnt[CNT_W-1:0];
		return r;
	endfunction

	function automatic void clear_line();
		line_in_params = 1'b0;
		line_done = 1'b0;
		line_err = 1'b0;
		byte_cnt = '0;
		cmd_len = '0;
		fld_phase = FP_IDLE;
		in_quote = 1'b0;
		fld_len = '0;
		param_cnt = '0;
	endfunction

	function automatic tok_result_t store(input target_t t, input logic [6:0] pos,
		input logic [CH_W-1:0] d);
		tok_result_t r;
		r = '0;
		r.target = t;
		r.param_index = ((t == TGT_PNAME || t == TGT_PVALUE) && param_cnt != 0) ?
			param_cnt - 4'd1 : 4'd0;
		r.position = pos[POS_W-1:0];
		r.data = d;
		return r;
	endfunction

	function automatic tok_result_t tokenize_byte(input logic [CH_W-1:0] c);
		tok_result_t r;
		r = '0;
		if (c == CH_NUL) begin
			if (!line_err) begin
				if (!line_in_params) begin
					r = store(TGT_CMD, cmd_len, CH_NUL);
				end else begin
					if (fld_phase == FP_VALUE && fld_len != 0) begin
						r = store(TGT_PVALUE, 7'(fld_len), CH_NUL);
						fld_phase = FP_IDLE;
					end else if (fld_phase == FP_NAME) begin
						r = store(TGT_PNAME, 7'(fld_len), CH_NUL);
					end
					if (fld_phase != FP_IDLE || in_quote)
						line_err = 1'b1;
				end
			end
			r.done_res = 1'b1;
			r.status = line_err;
			r.param_count = param_cnt;
			clear_line();
			return r;
		end
		if (byte_cnt >= LINE_MAX - 2)
			return r;
		byte_cnt++;
		if (line_done || line_err)
			return r;
		if (!line_in_params) begin
			if (c == CH_SPACE) begin
				if (cmd_len != 0) begin
					r = store(TGT_CMD, cmd_len, CH_NUL);
					line_in_params = 1'b1;
				end
			end else if (word_char(c)) begin
				r = store(TGT_CMD, cmd_len, c);
				cmd_len++;
			end else if (c == CH_QMARK && cmd_len == 0) begin
				r = store(TGT_CMD, 7'd0, c);
				cmd_len = 7'd1;
				line_done = 1'b1;
			end else begin
				line_err = 1'b1;
			end
		end else if (c == CH_SPACE) begin
			if (fld_phase == FP_VALUE && !in_quote) begin
				if (fld_len != 0) begin
					r = store(TGT_PVALUE, 7'(fld_len), CH_NUL);
					fld_len = '0;
					fld_phase = FP_IDLE;
				end
			end else if (in_quote) begin
				if (fld_phase == FP_VALUE) begin
					if (fld_len >= PARAM_VALUE_CHARS - 1) begin
						line_err = 1'b1;
					end else begin
						r = store(TGT_PVALUE, 7'(fld_len), c);
						fld_len++;
					end
				end else if (fld_phase == FP_NAME) begin
					line_err = 1'b1;
				end
			end
		end else if (c == CH_EQ) begin
			if (fld_phase == FP_NAME) begin
				r = store(TGT_PNAME, 7'(fld_len), CH_NUL);
				fld_len = '0;
				fld_phase = FP_VALUE;
			end else begin
				line_err = 1'b1;
			end
		end else if (c == CH_QUOTE) begin
			in_quote = !in_quote;
		end else begin
			if (fld_phase == FP_IDLE) begin
				if (param_cnt >= MAX_PARAMS) begin
					line_err = 1'b1;
					return r;
				end
				param_cnt++;
				fld_phase = FP_NAME;
				fld_len = '0;
			end
			if (fld_phase == FP_NAME) begin
				if (!word_char(c) || fld_len >= PARAM_NAME_CHARS - 1) begin
					line_err = 1'b1;
				end else begin
					r = store(TGT_PNAME, 7'(fld_len), c);
					fld_len++;
				end
			end else begin
				if (fld_len >= PARAM_VALUE_CHARS - 1) begin
					line_err = 1'b1;
				end else begin
					r = store(TGT_PVALUE, 7'(fld_len), c);
					fld_len++;
				end
			end
		end
		return r;
	endfunction

	function automatic int idle_len(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [CH_W-1:0] b, input bit fixed, input tok_result_t res);
		int gap;
		tok_result_t r;
		gap = idle_len(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= b;
		do @(posedge clk); while (!in_ready);
		r = tokenize_byte(b);
		pending_writes.push_back(fixed ? res : r);
		sent++;
	endtask

	task automatic add_row(input logic [CH_W-1:0] b, input bit fixed, input tok_result_t res);
		row_t row;
		row.b = b;
		row.fixed = fixed;
		row.res = res;
		plan.push_back(row);
	endtask

	function automatic logic [CH_W-1:0] rand_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 10)
			return 8'("0" + r);
		if (r < 36)
			return 8'("a" + r - 10);
		if (r < 62)
			return 8'("A" + r - 36);
		return CH_USCORE;
	endfunction

	function automatic logic [CH_W-1:0] rand_value_char();
		logic [CH_W-1:0] v;
		if ($urandom_range(0, 4) != 0)
			return rand_word_char();
		do v = 8'($urandom_range(1, 255));
		while (v == CH_SPACE || v == CH_EQ || v == CH_QUOTE);
		return v;
	endfunction

	function automatic logic [CH_W-1:0] rand_special();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_EQ;
			2: return CH_QUOTE;
			3: return CH_QMARK;
			4: return 8'($urandom_range(128, 255));
			default: return 8'($urandom_range(1, 31));
		endcase
	endfunction

	task automatic make_line();
		int kind, n, np, nl, vl;
		bit many, quoted_val;
		line_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(0, 70);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					line_q.push_back(rand_special());
				else
					line_q.push_back(8'($urandom_range(1, 255)));
			end
			return;
		end
		repeat ($urandom_range(0, 3)) line_q.push_back(CH_SPACE);
		if ($urandom_range(0, 9) == 0) begin
			line_q.push_back(CH_QMARK);
			repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 8);
			repeat (n) line_q.push_back(rand_word_char());
			many = ($urandom_range(0, 3) == 0);
			np = many ? $urandom_range(8, 12) : $urandom_range(0, 4);
			repeat (np) begin
				repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
				nl = many ? $urandom_range(1, 2) :
					($urandom_range(0, 9) == 0 ? $urandom_range(8, 11) : $urandom_range(1, 6));
				repeat (nl) begin
					line_q.push_back(rand_word_char());
					if ($urandom_range(0, 29) == 0)
						line_q.push_back(CH_SPACE);
				end
				line_q.push_back(CH_EQ);
				if ($urandom_range(0, 7) == 0)
					line_q.push_back(CH_SPACE);
				quoted_val = ($urandom_range(0, 3) == 0);
				if (quoted_val)
					line_q.push_back(CH_QUOTE);
				vl = ($urandom_range(0, 11) == 0) ? 0 : many ? $urandom_range(1, 2) :
					($urandom_range(0, 9) == 0 ? $urandom_range(17, 22) : $urandom_range(1, 8));
				repeat (vl) begin
					if (quoted_val && $urandom_range(0, 3) == 0)
						line_q.push_back(CH_SPACE);
					else
						line_q.push_back(rand_value_char());
				end
				if (quoted_val && $urandom_range(0, 7) != 0)
					line_q.push_back(CH_QUOTE);
			end
		end
		if (kind < 25 && line_q.size() > 0)
			repeat ($urandom_range(1, 2))
				line_q[$urandom_range(0, line_q.size() - 1)] = rand_special();
	endtask

	task automatic flag(input string what, input logic [7:0] e, input logic [7:0] a);
		$display("%0t %s mismatch: expected %0d, got %0d", $time, what, e, a);
		fails++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t result item with none expected: target %0d data %0d",
					$time, target, data);
				fails++;
			end else begin
				want = pending_writes.pop_front();
				if (target !== want.target)
					flag("target", 8'(want.target), 8'(target));
				if (param_index !== want.param_index)
					flag("param_index", 8'(want.param_index), 8'(param_index));
				if (position !== want.position)
					flag("position", 8'(want.position), 8'(position));
				if (data !== want.data)
					flag("data", want.data, data);
				if (done_res !== want.done_res)
					flag("done_res", 8'(want.done_res), 8'(done_res));
				if (status !== want.status)
					flag("status", 8'(want.status), 8'(status));
				if (param_count !== want.param_count)
					flag("param_count", 8'(want.param_count), 8'(param_count));
			end
		end
		if (hold_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
					$urandom_range(1, 30);
			end else begin
				out_ready <= 1'b0;
				hold_left = idle_len(1'b0) + 1;
			end
		end else begin
			hold_left--;
		end
	end

	initial begin
		int lines;
		lines = 0;
		clear_line();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(CH_QMARK, 1, res_of(TGT_CMD, 0, 0, CH_QMARK, 0, 0, 0));
		add_row(8'hFF, 1, '0);
		add_row(CH_NUL, 1, res_of(TGT_CMD, 0, 1, CH_NUL, 1, 0, 0));
		add_row(8'h80, 1, '0);
		add_row(CH_NUL, 1, res_of(TGT_NONE, 0, 0, CH_NUL, 1, 1, 0));
		add_row(CH_SPACE, 1, '0);
		add_row("a", 1, res_of(TGT_CMD, 0, 0, "a", 0, 0, 0));
		add_row(CH_SPACE, 1, res_of(TGT_CMD, 0, 1, CH_NUL, 0, 0, 0));
		add_row("x", 0, '0);
		add_row(CH_EQ, 0, '0);
		add_row(CH_QUOTE, 0, '0);
		add_row(CH_SPACE, 0, '0);
		add_row(CH_QUOTE, 0, '0);
		add_row("Z", 0, '0);
		add_row(CH_NUL, 0, '0);
		add_row(CH_USCORE, 1, res_of(TGT_CMD, 0, 0, CH_USCORE, 0, 0, 0));
		add_row(CH_EQ, 1, '0);
		add_row(CH_NUL, 1, res_of(TGT_NONE, 0, 0, CH_NUL, 1, 1, 0));
		add_row("9", 0, '0);
		add_row(CH_SPACE, 0, '0);
		add_row("k", 0, '0);
		add_row(CH_SPACE, 0, '0);
		add_row(CH_QUOTE, 0, '0);
		add_row(CH_SPACE, 0, '0);
		add_row(CH_NUL, 0, '0);
		foreach (plan[i])
			send_byte(plan[i].b, plan[i].fixed, plan[i].res);

		while (sent < ITEMS) begin
			make_line();
			calm = ($urandom_range(0, 9) < 3);
			foreach (line_q[i])
				send_byte(line_q[i], 0, '0);
			send_byte(CH_NUL, 0, '0);
			lines++;
			if (lines == 15) begin
				in_valid <= 1'b0;
				while (pending_writes.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending_writes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
